FILE: rtl/rws_pkg.sv
// Package for the roulette wheel selection block.
// Holds sizes, command codes and the word types used by the top level.
// No dependencies.
package rws_pkg;

    localparam int POP_MAX  = 64;
    localparam int FIT_BITS = 16;
    localparam int IDX_W    = $clog2(POP_MAX);
    localparam int CNT_W    = IDX_W + 1;
    localparam int CUM_W    = FIT_BITS + IDX_W;
    localparam int DRAW_W   = 17;
    localparam int SCALED_W = CUM_W + DRAW_W;
    localparam int MC_W     = 7;

    localparam logic [MC_W-1:0]   MC_RESET   = 7'd64;
    localparam logic [DRAW_W-1:0] DRAW_SCALE = 17'd100000;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    typedef struct packed {
        logic                command;
        logic                start_req;
        logic [FIT_BITS-1:0] fitness;
        logic [DRAW_W-1:0]   draw;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] selected_index;
        logic             found;
    } t_out_word;

endpackage

FILE: rtl/rws_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rws_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/roulette_wheel_selection_top.sv
// Top level of the roulette wheel selection block.
// Depends on rws_pkg and rws_ram (cumulative fitness memory).
//
// Channel   Direction  Handshake                Word
// in        input      i_in_valid / o_in_stall  t_in_word  (load or draw command)
// out       output     o_out_valid / i_out_stall t_out_word (one per draw)
// cfg       input      i_cfg_we                 member_count, 7 bits
//
// A draw word goes through setup, a binary search over the memory with one
// read per step when the total is not zero, and a done state. A draw above the
// scale after a partial load adds a linear scan over the entries not loaded
// since the last restart, one read a cycle. Reset clears the total, the load
// pointer and the output valid flag; the memory is not cleared. A stalled
// output word holds the finished result back in a done state.
module roulette_wheel_selection_top
    import rws_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  t_in_word        i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output t_out_word       o_out_data,
    input  logic            i_cfg_we,
    input  logic [MC_W-1:0] i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_BSEARCH,
        S_LSCAN,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [MC_W-1:0]     r_member_count;
    logic [CUM_W-1:0]    r_total, n_total;
    logic [SCALED_W-1:0] r_scaled_total, n_scaled_total;
    logic [CNT_W-1:0]    r_ptr, n_ptr;
    logic [SCALED_W-1:0] r_lhs, n_lhs;
    logic [IDX_W-1:0]    r_lo, n_lo;
    logic [IDX_W-1:0]    r_hi, n_hi;
    logic [IDX_W-1:0]    r_addr, n_addr;
    t_out_word           r_res, n_res;
    logic                r_out_valid;
    t_out_word           r_out;

    logic [CNT_W-1:0]    w_count;
    logic [CNT_W-1:0]    w_limit;
    logic [IDX_W-1:0]    w_hi0;
    logic                w_in_acc;
    logic                w_out_free;
    logic [CNT_W-1:0]    w_base_ptr;
    logic [CUM_W-1:0]    w_base_total;
    logic [SCALED_W-1:0] w_base_scaled;
    logic                w_load_ok;
    logic [CUM_W-1:0]    w_new_total;
    logic [SCALED_W-1:0] w_new_scaled;
    logic                w_we;
    logic [SCALED_W-1:0] w_rdata;
    logic                w_hit;

    // The memory keeps 100000 * cumulative fitness, so a search step is one
    // compare against the registered product draw * total.
    rws_ram #(
        .W (SCALED_W),
        .D (POP_MAX)
    ) u_cum_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_base_ptr[IDX_W-1:0]),
        .i_wdata (w_new_scaled),
        .i_raddr (n_addr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        if (r_member_count == '0) begin
            w_count = CNT_W'(1);
        end else if (32'(r_member_count) > 32'(POP_MAX)) begin
            w_count = CNT_W'(POP_MAX);
        end else begin
            w_count = CNT_W'(r_member_count);
        end
    end

    assign w_limit    = (r_ptr < w_count) ? r_ptr : w_count;
    assign w_hi0      = IDX_W'(w_limit - CNT_W'(1));
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_base_ptr    = i_in_data.start_req ? '0 : r_ptr;
    assign w_base_total  = i_in_data.start_req ? '0 : r_total;
    assign w_base_scaled = i_in_data.start_req ? '0 : r_scaled_total;
    assign w_load_ok     = (w_base_ptr < w_count);
    assign w_new_total   = w_base_total + CUM_W'(i_in_data.fitness);
    assign w_new_scaled  = w_base_scaled
                         + SCALED_W'(i_in_data.fitness) * SCALED_W'(DRAW_SCALE);
    assign w_we          = w_in_acc && (i_in_data.command == CMD_LOAD) && w_load_ok;

    // Loads write only in idle and read data is used only during a search, so a
    // write never meets a read whose data the search uses.
    assign w_hit = (r_lhs <= w_rdata);

    always_comb begin
        logic [IDX_W-1:0] v_lo;
        logic [IDX_W-1:0] v_hi;
        v_lo           = r_lo;
        v_hi           = r_hi;
        n_state        = r_state;
        n_total        = r_total;
        n_scaled_total = r_scaled_total;
        n_ptr          = r_ptr;
        n_lhs          = r_lhs;
        n_lo           = r_lo;
        n_hi           = r_hi;
        n_addr         = r_addr;
        n_res          = r_res;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.command == CMD_LOAD) begin
                        n_total        = w_base_total;
                        n_scaled_total = w_base_scaled;
                        n_ptr          = w_base_ptr;
                        if (w_load_ok) begin
                            n_total        = w_new_total;
                            n_scaled_total = w_new_scaled;
                            n_ptr          = w_base_ptr + CNT_W'(1);
                        end
                    end else begin
                        n_lhs   = SCALED_W'(i_in_data.draw) * SCALED_W'(r_total);
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                if (r_total == '0) begin
                    n_res.selected_index = '0;
                    n_res.found          = 1'b0;
                    n_state              = S_DONE;
                end else begin
                    n_lo    = '0;
                    n_hi    = w_hi0;
                    n_addr  = w_hi0 >> 1;
                    n_state = S_BSEARCH;
                end
            end
            S_BSEARCH: begin
                if (r_lo == r_hi) begin
                    // Final check of the one remaining candidate.
                    if (w_hit) begin
                        n_res.selected_index = r_lo;
                        n_res.found          = 1'b1;
                        n_state              = S_DONE;
                    end else if (r_ptr < w_count) begin
                        n_addr  = r_ptr[IDX_W-1:0];
                        n_state = S_LSCAN;
                    end else begin
                        n_res.selected_index = '0;
                        n_res.found          = 1'b0;
                        n_state              = S_DONE;
                    end
                end else begin
                    if (w_hit) begin
                        v_hi = r_addr;
                    end else begin
                        v_lo = r_addr + IDX_W'(1);
                    end
                    n_lo   = v_lo;
                    n_hi   = v_hi;
                    n_addr = IDX_W'((CNT_W'(v_lo) + CNT_W'(v_hi)) >> 1);
                end
            end
            S_LSCAN: begin
                // Entries past the load pointer hold words from an earlier load
                // pass and are not ordered, so they are checked one by one.
                if (w_hit) begin
                    n_res.selected_index = r_addr;
                    n_res.found          = 1'b1;
                    n_state              = S_DONE;
                end else if (CNT_W'(r_addr) == w_count - CNT_W'(1)) begin
                    n_res.selected_index = '0;
                    n_res.found          = 1'b0;
                    n_state              = S_DONE;
                end else begin
                    n_addr = r_addr + IDX_W'(1);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_member_count <= MC_RESET;
            r_total        <= '0;
            r_scaled_total <= '0;
            r_ptr          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_total        <= n_total;
            r_scaled_total <= n_scaled_total;
            r_ptr          <= n_ptr;
            if (i_cfg_we) begin
                r_member_count <= i_cfg_wdata;
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_lhs  <= n_lhs;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_addr <= n_addr;
        r_res  <= n_res;
        if ((r_state == S_DONE) && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= CNT_W'(POP_MAX))
        else $error("load pointer beyond the memory depth");

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BSEARCH) |-> (r_lo <= r_hi))
        else $error("binary search bounds crossed");

    a_draw_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_data.command == CMD_SELECT)) |=> o_in_stall)
        else $error("draw word accepted without entering the search");

    a_zero_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SETUP) && (r_total == '0)) |=> ((r_state == S_DONE) && !r_res.found))
        else $error("zero total did not give an empty result");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.found) |-> (CNT_W'(o_out_data.selected_index) < w_count))
        else $error("selected index outside the active members");

endmodule
